// ----- src/nearest_point_table_assert.svh -----
// Assertion macros shared by the nearest point table RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef NEAREST_POINT_TABLE_ASSERT_SVH
`define NEAREST_POINT_TABLE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define NPT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define NPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NPT_ASSERT(lbl, ante, cons, msg)
`define NPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/npt_pkg.sv -----
// Package for the nearest point table: sizes, operation and status codes,
// and the command and status structs between controller and datapath.
`default_nettype none

package npt_pkg;

  // Table size and the widths derived from it.
  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);

  // Field widths.
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned NEXT_ID_W = 17;
  localparam int unsigned DIST_W    = 33;
  localparam int unsigned ROOT_W    = 17;
  localparam int unsigned OUT_CNT_W = 7;
  localparam int unsigned SLOT_W    = ID_W + 2 * COORD_W;

  // Square root unit: one result bit per step.
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned SQRT_CNT_W = $clog2(SQRT_STEPS);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_POINTS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_POINTS);

  // Operation codes carried in func.
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_NEAR = 2'd2;

  // Result status codes.
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_MISS = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  // Commands from the controller.
  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
    logic out_load;
  } npt_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic root_busy;
  } npt_sts_t;

endpackage

`default_nettype wire

// ----- src/npt_if.sv -----
// Valid/ready channel interfaces for the request and result streams.
// Depends on npt_pkg for the field widths.
`default_nettype none

interface npt_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [npt_pkg::COORD_W-1:0]  coord_x;
  logic signed [npt_pkg::COORD_W-1:0]  coord_y;
  logic [npt_pkg::ID_W-1:0]            target_id;

  modport source (output valid, func, coord_x, coord_y, target_id, input ready);
  modport sink   (input valid, func, coord_x, coord_y, target_id, output ready);
endinterface

interface npt_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [npt_pkg::ID_W-1:0]            found_id;
  logic signed [npt_pkg::COORD_W-1:0]  found_x;
  logic signed [npt_pkg::COORD_W-1:0]  found_y;
  logic [npt_pkg::DIST_W-1:0]          dist_sq;
  logic [npt_pkg::ROOT_W-1:0]          dist_res;
  logic [npt_pkg::OUT_CNT_W-1:0]       entry_count;

  modport source (output valid, status, found_id, found_x, found_y, dist_sq, dist_res,
                  entry_count, input ready);
  modport sink   (input valid, status, found_id, found_x, found_y, dist_sq, dist_res,
                  entry_count, output ready);
endinterface

`default_nettype wire

// ----- src/npt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
`default_nettype none

module npt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- src/npt_sqrt.sv -----
// Iterative floor square root, one root bit per cycle.
// Depends on npt_pkg for the radicand and root widths.
`default_nettype none

`include "nearest_point_table_assert.svh"

module npt_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [npt_pkg::DIST_W-1:0]  radicand,
  output logic                        busy,
  output logic [npt_pkg::ROOT_W-1:0]  root
);

  localparam int unsigned RAD_W = 2 * npt_pkg::ROOT_W;
  localparam int unsigned REM_W = npt_pkg::ROOT_W + 3;

  logic                            busy_r, busy_nxt;
  logic [npt_pkg::SQRT_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RAD_W-1:0]                rad_r, rad_nxt;
  logic [REM_W-1:0]                rem_r, rem_nxt;
  logic [npt_pkg::ROOT_W-1:0]      q_r, q_nxt;
  logic [REM_W-1:0]                rem_sh;
  logic [REM_W-1:0]                trial;
  logic                            take;

  // One restoring step: bring down two radicand bits and try root*4+1.
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = {1'b0, q_r, 2'b01};
  assign take   = (rem_sh >= trial);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = npt_pkg::SQRT_CNT_W'(npt_pkg::SQRT_STEPS - 1);
      rad_nxt  = RAD_W'(radicand);
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt = take ? (rem_sh - trial) : rem_sh;
      q_nxt   = {q_r[npt_pkg::ROOT_W-2:0], take};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // Control state is reset; the working registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign root = q_r;

  // A new root is only requested once the previous one has finished.
  `NPT_ASSERT(a_sqrt_start_idle, start, !busy_r, "square root restarted while busy")

endmodule

`default_nettype wire

// ----- src/npt_dp.sv -----
// Datapath of the nearest point table: slot memory, valid bits, the scan
// pipeline, result tracking and the output register. Uses npt_pkg, npt_ram, npt_sqrt.
`default_nettype none

`include "nearest_point_table_assert.svh"

module npt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  npt_pkg::npt_cmd_t                   cmd,
  output npt_pkg::npt_sts_t                   sts,
  input  logic [1:0]                          in_func,
  input  logic signed [npt_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [npt_pkg::COORD_W-1:0]  in_coord_y,
  input  logic [npt_pkg::ID_W-1:0]            in_target_id,
  output logic [1:0]                          out_status,
  output logic [npt_pkg::ID_W-1:0]            out_found_id,
  output logic signed [npt_pkg::COORD_W-1:0]  out_found_x,
  output logic signed [npt_pkg::COORD_W-1:0]  out_found_y,
  output logic [npt_pkg::DIST_W-1:0]          out_dist_sq,
  output logic [npt_pkg::ROOT_W-1:0]          out_dist_res,
  output logic [npt_pkg::OUT_CNT_W-1:0]       out_entry_count
);

  localparam int unsigned CW = npt_pkg::COORD_W;
  localparam int unsigned IW = npt_pkg::IDX_W;
  localparam int unsigned DW = npt_pkg::ID_W;

  // Latched request.
  logic [1:0]    op_r;
  logic [CW-1:0] qx_r, qy_r;
  logic [DW-1:0] tid_r;

  // Table state.
  logic [npt_pkg::MAX_POINTS-1:0] valid_r;
  logic [npt_pkg::CNT_W-1:0]      count_r;
  logic [npt_pkg::NEXT_ID_W-1:0]  next_id_r;

  // Scan address counter.
  logic [IW-1:0] scan_idx_r;

  // Slot memory.
  logic                       ram_we;
  logic [npt_pkg::SLOT_W-1:0] ram_wdata;
  logic [npt_pkg::SLOT_W-1:0] ram_rdata;
  logic [DW-1:0]              rd_id;
  logic [CW-1:0]              rd_x, rd_y;

  // Scan pipeline stages.
  logic          s1_act_r, s1_v_r;
  logic [IW-1:0] s1_idx_r;
  logic          s2_act_r, s2_v_r;
  logic [IW-1:0] s2_idx_r;
  logic [DW-1:0] s2_id_r;
  logic [CW-1:0] s2_x_r, s2_y_r;
  logic [CW:0]   s2_dx_r, s2_dy_r;
  logic          s3_act_r, s3_v_r;
  logic [IW-1:0] s3_idx_r;
  logic [DW-1:0] s3_id_r;
  logic [CW-1:0] s3_x_r, s3_y_r;
  logic [2*CW-1:0] s3_sqx_r, s3_sqy_r;
  logic          s4_act_r, s4_v_r;
  logic [IW-1:0] s4_idx_r;
  logic [DW-1:0] s4_id_r;
  logic [CW-1:0] s4_x_r, s4_y_r;
  logic [npt_pkg::DIST_W-1:0] s4_sum_r;

  logic [CW:0]     dx_c, dy_c;
  logic [CW:0]     absx_c, absy_c;
  logic [CW-1:0]   ax_c, ay_c;
  logic [2*CW-1:0] sqx_c, sqy_c;

  // Tracking over the scan.
  logic                       have_r;
  logic [npt_pkg::DIST_W-1:0] best_r;
  logic [DW-1:0]              best_id_r;
  logic [CW-1:0]              best_x_r, best_y_r;
  logic                       hit_r, free_r;
  logic [IW-1:0]              hit_idx_r, free_idx_r;
  logic                       near_take, hit_take, free_take;

  // Commit decisions and held results.
  logic          add_ok, del_ok, near_ok;
  logic [1:0]    res_status_r;
  logic [DW-1:0] res_id_r;
  logic          res_near_r;

  logic                       root_busy;
  logic [npt_pkg::ROOT_W-1:0] root;

  // Output register.
  logic [1:0]                    o_status_r;
  logic [DW-1:0]                 o_id_r;
  logic [CW-1:0]                 o_x_r, o_y_r;
  logic [npt_pkg::DIST_W-1:0]    o_dsq_r;
  logic [npt_pkg::ROOT_W-1:0]    o_dres_r;
  logic [npt_pkg::OUT_CNT_W-1:0] o_cnt_r;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_func;
      qx_r  <= in_coord_x;
      qy_r  <= in_coord_y;
      tid_r <= in_target_id;
    end
  end

  // Scan counter walks every slot once per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= (scan_idx_r == npt_pkg::IDX_LAST) ? '0 : scan_idx_r + 1'b1;
    end
  end

  // Slot memory: written on commit of an add, read during the scan.
  assign ram_we    = cmd.commit && add_ok;
  assign ram_wdata = {next_id_r[DW-1:0], qx_r, qy_r};

  npt_ram #(
    .WIDTH (npt_pkg::SLOT_W),
    .DEPTH (npt_pkg::MAX_POINTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (ram_wdata),
    .re    (cmd.scan_step),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  assign rd_id = ram_rdata[npt_pkg::SLOT_W-1 -: DW];
  assign rd_x  = ram_rdata[2*CW-1 -: CW];
  assign rd_y  = ram_rdata[CW-1:0];

  // Stage arithmetic: differences, magnitudes and squares.
  assign dx_c   = {rd_x[CW-1], rd_x} - {qx_r[CW-1], qx_r};
  assign dy_c   = {rd_y[CW-1], rd_y} - {qy_r[CW-1], qy_r};
  assign absx_c = s2_dx_r[CW] ? ((CW+1)'(0) - s2_dx_r) : s2_dx_r;
  assign absy_c = s2_dy_r[CW] ? ((CW+1)'(0) - s2_dy_r) : s2_dy_r;
  assign ax_c   = absx_c[CW-1:0];
  assign ay_c   = absy_c[CW-1:0];
  assign sqx_c  = {{CW{1'b0}}, ax_c} * {{CW{1'b0}}, ax_c};
  assign sqy_c  = {{CW{1'b0}}, ay_c} * {{CW{1'b0}}, ay_c};

  // Pipeline stage flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_act_r <= 1'b0;
      s2_act_r <= 1'b0;
      s3_act_r <= 1'b0;
      s4_act_r <= 1'b0;
    end else begin
      s1_act_r <= cmd.scan_step;
      s2_act_r <= s1_act_r;
      s3_act_r <= s2_act_r;
      s4_act_r <= s3_act_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    s1_v_r   <= valid_r[scan_idx_r];
    s1_idx_r <= scan_idx_r;
    s2_v_r   <= s1_v_r;
    s2_idx_r <= s1_idx_r;
    s2_id_r  <= rd_id;
    s2_x_r   <= rd_x;
    s2_y_r   <= rd_y;
    s2_dx_r  <= dx_c;
    s2_dy_r  <= dy_c;
    s3_v_r   <= s2_v_r;
    s3_idx_r <= s2_idx_r;
    s3_id_r  <= s2_id_r;
    s3_x_r   <= s2_x_r;
    s3_y_r   <= s2_y_r;
    s3_sqx_r <= sqx_c;
    s3_sqy_r <= sqy_c;
    s4_v_r   <= s3_v_r;
    s4_idx_r <= s3_idx_r;
    s4_id_r  <= s3_id_r;
    s4_x_r   <= s3_x_r;
    s4_y_r   <= s3_y_r;
    s4_sum_r <= {1'b0, s3_sqx_r} + {1'b0, s3_sqy_r};
  end

  // Per-slot decisions at the last stage; ties go to the lower id.
  assign near_take = s4_act_r && s4_v_r &&
                     (!have_r || (s4_sum_r < best_r) ||
                      ((s4_sum_r == best_r) && (s4_id_r < best_id_r)));
  assign hit_take  = s4_act_r && s4_v_r && !hit_r && (s4_id_r == tid_r);
  assign free_take = s4_act_r && !s4_v_r && !free_r;

  // Tracking flags.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      have_r <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      if (near_take) begin
        have_r <= 1'b1;
      end
      if (hit_take) begin
        hit_r <= 1'b1;
      end
      if (free_take) begin
        free_r <= 1'b1;
      end
    end
  end

  // Tracking payload.
  always_ff @(posedge clk) begin
    if (near_take) begin
      best_r    <= s4_sum_r;
      best_id_r <= s4_id_r;
      best_x_r  <= s4_x_r;
      best_y_r  <= s4_y_r;
    end
    if (hit_take) begin
      hit_idx_r <= s4_idx_r;
    end
    if (free_take) begin
      free_idx_r <= s4_idx_r;
    end
  end

  // Commit decisions.
  assign add_ok  = (op_r == npt_pkg::OP_ADD) && (count_r < npt_pkg::CNT_MAX) &&
                   !next_id_r[npt_pkg::NEXT_ID_W-1] && free_r;
  assign del_ok  = (op_r == npt_pkg::OP_DEL) && hit_r;
  assign near_ok = (op_r == npt_pkg::OP_NEAR) && have_r;

  // Table state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      count_r   <= '0;
      next_id_r <= npt_pkg::NEXT_ID_W'(1);
    end else if (cmd.commit) begin
      if (add_ok) begin
        valid_r[free_idx_r] <= 1'b1;
        count_r             <= count_r + 1'b1;
        next_id_r           <= next_id_r + 1'b1;
      end else if (del_ok) begin
        valid_r[hit_idx_r] <= 1'b0;
        count_r            <= count_r - 1'b1;
      end
    end
  end

  // Result fields held from commit.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_near_r <= near_ok;
      unique case (op_r)
        npt_pkg::OP_ADD: begin
          res_status_r <= add_ok ? npt_pkg::STS_OK : npt_pkg::STS_FULL;
          res_id_r     <= add_ok ? next_id_r[DW-1:0] : '0;
        end
        npt_pkg::OP_DEL: begin
          res_status_r <= del_ok ? npt_pkg::STS_OK : npt_pkg::STS_MISS;
          res_id_r     <= del_ok ? tid_r : '0;
        end
        npt_pkg::OP_NEAR: begin
          res_status_r <= near_ok ? npt_pkg::STS_OK : npt_pkg::STS_MISS;
          res_id_r     <= near_ok ? best_id_r : '0;
        end
        default: begin
          res_status_r <= npt_pkg::STS_MISS;
          res_id_r     <= '0;
        end
      endcase
    end
  end

  // Square root of the best distance.
  npt_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.commit),
    .radicand (best_r),
    .busy     (root_busy),
    .root     (root)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status_r <= res_status_r;
      o_id_r     <= res_id_r;
      o_x_r      <= res_near_r ? best_x_r : '0;
      o_y_r      <= res_near_r ? best_y_r : '0;
      o_dsq_r    <= res_near_r ? best_r : '0;
      o_dres_r   <= res_near_r ? root : '0;
      o_cnt_r    <= npt_pkg::OUT_CNT_W'(count_r);
    end
  end

  assign out_status      = o_status_r;
  assign out_found_id    = o_id_r;
  assign out_found_x     = o_x_r;
  assign out_found_y     = o_y_r;
  assign out_dist_sq     = o_dsq_r;
  assign out_dist_res    = o_dres_r;
  assign out_entry_count = o_cnt_r;

  // Status to the controller.
  assign sts.scan_last = (scan_idx_r == npt_pkg::IDX_LAST);
  assign sts.pipe_busy = s1_act_r || s2_act_r || s3_act_r || s4_act_r;
  assign sts.root_busy = root_busy;

  // The entry count always tracks the set of valid slots.
  `NPT_ASSERT(a_count_matches, 1'b1, $countones(valid_r) == int'(count_r),
              "entry count differs from number of valid slots")
  // A delete only clears a slot that is valid.
  `NPT_ASSERT(a_del_valid, cmd.commit && del_ok, valid_r[hit_idx_r],
              "delete commit on an invalid slot")
  // An add only fills a slot that is free.
  `NPT_ASSERT(a_add_free, cmd.commit && add_ok, !valid_r[free_idx_r],
              "add commit on an occupied slot")

endmodule

`default_nettype wire

// ----- src/npt_ctrl.sv -----
// Controller of the nearest point table: sequences accept, scan, drain,
// commit, square root and result. Uses npt_pkg for the command and status structs.
`default_nettype none

`include "nearest_point_table_assert.svh"

module npt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output npt_pkg::npt_cmd_t cmd,
  input  npt_pkg::npt_sts_t sts
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_COMMIT = 6'b001000,
    ST_ROOT   = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        if (!sts.root_busy) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The output register holds a result until its transaction completes.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // An accepted request always starts a scan.
  `NPT_ASSERT_NEXT(a_load_scans, cmd.load, state_r == ST_SCAN,
                   "accepted request did not start a scan")
  // A result is loaded only into a free or draining output register.
  `NPT_ASSERT(a_out_free, cmd.out_load, !out_valid_r || out_ready,
              "result overwrote a pending output")

endmodule

`default_nettype wire

// ----- src/nearest_point_table.sv -----
// Top level of the nearest point table: controller plus datapath.
// Depends on npt_pkg, npt_if, npt_ctrl and npt_dp.
//
//  Channel  Direction  Handshake    Payload
//  in_ch    sink       valid/ready  func, coord_x, coord_y, target_id
//  out_ch   source     valid/ready  status, found_id, found_x, found_y, dist_sq,
//                                   dist_res, entry_count
//
// Every operation scans the slot memory one entry per cycle through a four-stage
// distance pipeline, then runs the 17-step square root unit.
// Reset is synchronous and active low; it clears the valid bits at once, so no
// clearing pass follows it. A new request is taken while a result still waits in
// the output register; a stalled output keeps the next result in the datapath.
`default_nettype none

module nearest_point_table (
  input  logic       clk,
  input  logic       rst_n,
  npt_in_if.sink     in_ch,
  npt_out_if.source  out_ch
);

  npt_pkg::npt_cmd_t cmd;
  npt_pkg::npt_sts_t sts;

  // Sequencing.
  npt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Storage, scan and results.
  npt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_ch.func),
    .in_coord_x      (in_ch.coord_x),
    .in_coord_y      (in_ch.coord_y),
    .in_target_id    (in_ch.target_id),
    .out_status      (out_ch.status),
    .out_found_id    (out_ch.found_id),
    .out_found_x     (out_ch.found_x),
    .out_found_y     (out_ch.found_y),
    .out_dist_sq     (out_ch.dist_sq),
    .out_dist_res    (out_ch.dist_res),
    .out_entry_count (out_ch.entry_count)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the nearest point table: adds, deletes and nearest
// queries are driven over the request channel and every result is checked against
// a behavioral table model. Depends on npt_pkg, npt_if and the nearest_point_table RTL.
module tb_top;
  import npt_pkg::*;

  // The fourth selector value has no package name; the block answers it with a miss.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int unsigned LATENCY = MAX_POINTS + 26;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AFTER = 300;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic [ID_W-1:0]            target_id;
  } point_req_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [ID_W-1:0]            found_id;
    logic signed [COORD_W-1:0]  found_x;
    logic signed [COORD_W-1:0]  found_y;
    logic [DIST_W-1:0]          dist_sq;
    logic [ROOT_W-1:0]          dist_res;
    logic [OUT_CNT_W-1:0]       entry_count;
  } point_rsp_t;

  // Entry that the stimulus generator believes to be live in the table.
  typedef struct {
    int                         id;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } live_pt_t;

  logic clk;
  logic rst_n;

  npt_in_if  in_ch();
  npt_out_if out_ch();

  nearest_point_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the point table used for prediction.
  bit                         tbl_valid [MAX_POINTS];
  logic [ID_W-1:0]            tbl_id    [MAX_POINTS];
  logic signed [COORD_W-1:0]  tbl_x     [MAX_POINTS];
  logic signed [COORD_W-1:0]  tbl_y     [MAX_POINTS];
  logic [NEXT_ID_W-1:0]       id_next = NEXT_ID_W'(1);
  int                         live_cnt = 0;

  point_req_t request_q [$];
  point_rsp_t outcome_q [$];
  point_req_t cur_req;

  // Generator-side view of which ids are live.
  live_pt_t gen_pts [$];
  int       gen_next_id = 1;
  int       gen_total = 0;

  bit calm = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int taken_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int bad_cnt = 0;
  int result_cnt = 0;

  // Coverage tallies for the summary.
  int n_add_ok = 0, n_add_full = 0, n_del_hit = 0, n_del_miss = 0;
  int n_near_hit = 0, n_near_empty = 0, n_ties = 0, n_full_seen = 0, n_spare = 0;

  // Applies one operation to the shadow table and returns the expected result.
  function automatic point_rsp_t table_outcome(input point_req_t rq);
    point_rsp_t      rs;
    int              slot;
    int              best_slot;
    bit              have;
    longint          dx, dy, sq_dist, best, root, trial;
    logic [ID_W-1:0] best_id;
    rs = '0;
    rs.status = STS_MISS;
    case (rq.func)
      OP_ADD: begin
        if (live_cnt >= MAX_POINTS || id_next > NEXT_ID_W'(65535)) begin
          rs.status = STS_FULL;
          n_add_full++;
        end else begin
          slot = 0;
          while (tbl_valid[slot]) slot++;
          tbl_valid[slot] = 1'b1;
          tbl_id[slot] = id_next[ID_W-1:0];
          tbl_x[slot] = rq.coord_x;
          tbl_y[slot] = rq.coord_y;
          rs.status = STS_OK;
          rs.found_id = id_next[ID_W-1:0];
          id_next++;
          live_cnt++;
          n_add_ok++;
          if (live_cnt == MAX_POINTS) n_full_seen++;
        end
      end
      OP_DEL: begin
        have = 1'b0;
        for (slot = 0; slot < MAX_POINTS && !have; slot++) begin
          if (tbl_valid[slot] && tbl_id[slot] == rq.target_id) begin
            tbl_valid[slot] = 1'b0;
            live_cnt--;
            rs.status = STS_OK;
            rs.found_id = rq.target_id;
            have = 1'b1;
          end
        end
        if (have) n_del_hit++;
        else n_del_miss++;
      end
      OP_NEAR: begin
        have = 1'b0;
        best = 0;
        best_id = '0;
        best_slot = 0;
        for (slot = 0; slot < MAX_POINTS; slot++) begin
          if (tbl_valid[slot]) begin
            dx = longint'(tbl_x[slot]) - longint'(rq.coord_x);
            dy = longint'(tbl_y[slot]) - longint'(rq.coord_y);
            sq_dist = dx * dx + dy * dy;
            if (have && sq_dist == best) n_ties++;
            if (!have || sq_dist < best || (sq_dist == best && tbl_id[slot] < best_id)) begin
              have = 1'b1;
              best = sq_dist;
              best_id = tbl_id[slot];
              best_slot = slot;
            end
          end
        end
        if (have) begin
          // Floor square root, one result bit at a time from the top.
          root = 0;
          for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= best) root = trial;
          end
          rs.status = STS_OK;
          rs.found_id = best_id;
          rs.found_x = tbl_x[best_slot];
          rs.found_y = tbl_y[best_slot];
          rs.dist_sq = DIST_W'(best);
          rs.dist_res = ROOT_W'(root);
          n_near_hit++;
        end else begin
          n_near_empty++;
        end
      end
      default: n_spare++;
    endcase
    rs.entry_count = OUT_CNT_W'(live_cnt);
    return rs;
  endfunction

  // Coordinates from the full range, a coarse grid that makes ties, the extremes,
  // or a small area around the origin.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    int k;
    k = $urandom_range(0, 6);
    case ($urandom_range(0, 3))
      0: return COORD_W'($urandom);
      1: return COORD_W'((k - 3) * 256);
      2: begin
        case (k % 4)
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return COORD_W'(int'($urandom_range(0, 1200)) - 600);
    endcase
  endfunction

  task automatic push_req(input logic [1:0] f, input logic signed [COORD_W-1:0] x,
                          input logic signed [COORD_W-1:0] y, input logic [ID_W-1:0] tid);
    request_q.push_back('{func: f, coord_x: x, coord_y: y, target_id: tid});
    gen_total++;
  endtask

  task automatic add_pt(input logic signed [COORD_W-1:0] x,
                        input logic signed [COORD_W-1:0] y);
    push_req(OP_ADD, x, y, ID_W'($urandom));
    if (gen_pts.size() < MAX_POINTS) begin
      gen_pts.push_back('{id: gen_next_id, x: x, y: y});
      gen_next_id++;
    end
  endtask

  task automatic del_id(input logic [ID_W-1:0] tid);
    int idx;
    push_req(OP_DEL, pick_coord(), pick_coord(), tid);
    idx = -1;
    foreach (gen_pts[i]) if (gen_pts[i].id == int'(tid)) idx = i;
    if (idx >= 0) gen_pts.delete(idx);
  endtask

  task automatic del_live();
    if (gen_pts.size() == 0) del_id(ID_W'($urandom));
    else del_id(ID_W'(gen_pts[$urandom_range(0, gen_pts.size() - 1)].id));
  endtask

  task automatic near_at(input logic signed [COORD_W-1:0] x,
                         input logic signed [COORD_W-1:0] y);
    push_req(OP_NEAR, x, y, ID_W'($urandom));
  endtask

  // Queries mostly land close to a stored point, so that near misses and ties occur.
  task automatic near_pt();
    live_pt_t p;
    if (gen_pts.size() != 0 && $urandom_range(0, 2) != 0) begin
      p = gen_pts[$urandom_range(0, gen_pts.size() - 1)];
      near_at(p.x + COORD_W'(int'($urandom_range(0, 6)) - 3),
              p.y + COORD_W'(int'($urandom_range(0, 6)) - 3));
    end else begin
      near_at(pick_coord(), pick_coord());
    end
  endtask

  task automatic mixed_ops(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 38) add_pt(pick_coord(), pick_coord());
      else if (r < 55) del_live();
      else if (r < 58) del_id(ID_W'($urandom));
      else if (r < 61) del_id(ID_W'($urandom_range(0, gen_next_id + 2)));
      else if (r < 97) near_pt();
      else push_req(OP_SPARE, COORD_W'($urandom), COORD_W'($urandom), ID_W'($urandom));
    end
  endtask

  // Fill the table, knock on the full table, query it, then free about half.
  task automatic fill_table();
    while (gen_pts.size() < MAX_POINTS) add_pt(pick_coord(), pick_coord());
    repeat (3) add_pt(pick_coord(), pick_coord());
    repeat (10) near_pt();
    repeat (MAX_POINTS / 2) del_live();
  endtask

  task automatic empty_table();
    while (gen_pts.size() != 0) begin
      del_live();
      if ($urandom_range(0, 3) == 0) near_pt();
    end
    near_pt();
    del_id(ID_W'($urandom));
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_ch.valid || outcome_q.size() != 0) @(negedge clk);
  endtask

  // Clock, and known values on every input from time zero.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = OP_NEAR;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.target_id = '0;
    out_ch.ready = 1'b0;
    forever #6 clk = ~clk;
  end

  // Request driver: presents queued transactions and predicts each accepted one.
  always @(posedge clk) begin : drive_proc
    bit fire;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        outcome_q.push_back(table_outcome(cur_req));
        taken_cnt <= taken_cnt + 1;
      end
      if (!in_ch.valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (request_q.size() != 0 && !calm && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(0, 8);
          in_ch.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= cur_req.func;
          in_ch.coord_x <= cur_req.coord_x;
          in_ch.coord_y <= cur_req.coord_y;
          in_ch.target_id <= cur_req.target_id;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off on the result side, so the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && taken_cnt >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Result monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin : observe_proc
    point_rsp_t got;
    point_rsp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{status: out_ch.status, found_id: out_ch.found_id, found_x: out_ch.found_x,
                found_y: out_ch.found_y, dist_sq: out_ch.dist_sq, dist_res: out_ch.dist_res,
                entry_count: out_ch.entry_count};
        result_cnt++;
        if (outcome_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("result %0d arrived with nothing expected", result_cnt);
        end else begin
          want = outcome_q.pop_front();
          if (got.status !== want.status || got.found_id !== want.found_id ||
              got.found_x !== want.found_x || got.found_y !== want.found_y ||
              got.dist_sq !== want.dist_sq || got.dist_res !== want.dist_res ||
              got.entry_count !== want.entry_count) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $display("result %0d expected: st=%0d id=%0d x=%0d y=%0d dsq=%0d root=%0d cnt=%0d",
                       result_cnt, want.status, want.found_id, want.found_x, want.found_y,
                       want.dist_sq, want.dist_res, want.entry_count);
              $display("result %0d actual:   st=%0d id=%0d x=%0d y=%0d dsq=%0d root=%0d cnt=%0d",
                       result_cnt, got.status, got.found_id, got.found_x, got.found_y,
                       got.dist_sq, got.dist_res, got.entry_count);
            end
          end
        end
      end
      if (recv_gap > 0) recv_gap--;
      else if (!calm && $urandom_range(0, 11) == 0) recv_gap = $urandom_range(1, 9);
      out_ch.ready <= (recv_gap == 0) && (hold_left == 0);
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, spare selector, extreme corners with distance ties,
    // largest distance, absent ids, equal points, and a lower id in a higher slot.
    near_at(16'sh0000, 16'sh0000);
    del_id(16'h0000);
    push_req(OP_SPARE, 16'shFFFF, 16'shFFFF, 16'hFFFF);
    add_pt(16'sh7FFF, 16'sh7FFF);
    add_pt(16'sh8000, 16'sh8000);
    near_at(16'sh8000, 16'sh8000);
    near_at(16'sh7FFF, 16'sh8000);
    near_at(16'sh8000, 16'sh7FFF);
    del_id(16'd1);
    near_at(16'sh7FFF, 16'sh7FFF);
    del_id(16'd1);
    del_id(16'hFFFF);
    del_id(16'h0000);
    add_pt(16'sh0000, 16'sh0000);
    add_pt(16'sh0000, 16'sh0000);
    near_at(16'sh0000, 16'sh0000);
    add_pt(16'sh0100, 16'sh0000);
    add_pt(-16'sh0100, 16'sh0000);
    near_at(16'sh0000, 16'sh0100);
    del_id(16'd3);
    add_pt(16'sh0000, 16'sh0000);
    near_at(16'sh0000, 16'sh0000);
    wait_drained();

    // Random episodes of fills, drains and mixed traffic.
    while (gen_total < 1500) begin
      case ($urandom_range(0, 5))
        0: fill_table();
        1: empty_table();
        default: mixed_ops($urandom_range(20, 40));
      endcase
    end
    wait_drained();

    // Final stretch with no idling on either side.
    calm = 1'b1;
    while (gen_total < 1720) mixed_ops(20);
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);

    $display("Ran %0d transactions: %0d adds, %0d refused as full, %0d table-full events.",
             taken_cnt, n_add_ok, n_add_full, n_full_seen);
    $display("Deletes %0d hit / %0d missed; queries %0d found / %0d empty, %0d ties, %0d spare.",
             n_del_hit, n_del_miss, n_near_hit, n_near_empty, n_ties, n_spare);
    if (bad_cnt == 0 && outcome_q.size() == 0) begin
      $display("nearest_point_table verification clean");
    end else begin
      $display("%0d mismatches, %0d results still expected", bad_cnt, outcome_q.size());
      $display("nearest_point_table verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(12 * 1000000);
    $display("timeout with %0d results still expected", outcome_q.size());
    $display("nearest_point_table verification failed");
    $finish;
  end

endmodule
